@@ src/hbs_pkg.sv @@
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, constants and helpers of the heightfield bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned INV_W          = 24;
  localparam int unsigned DIM_W          = 9;
  localparam int unsigned FRAC_W         = 24;
  localparam int unsigned ADDR_W         = 18;
  localparam int unsigned IDX_W          = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned PROD_W         = 58;
  localparam int unsigned UV_W           = 56;
  localparam int unsigned QDEPTH         = 8;
  localparam int unsigned CNT_W          = $clog2(QDEPTH + 1);
  localparam int unsigned PTR_W          = $clog2(QDEPTH);
  localparam int unsigned GRID_CELLS_DEF = 65536;
  localparam int unsigned MAX_DIM_DEF    = 256;

  localparam logic [INV_W-1:0] INV_RESET = 24'h01_0000;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Z    = 3'd1,
    CFG_INV_TEXEL_X = 3'd2,
    CFG_INV_TEXEL_Z = 3'd3,
    CFG_GRID_WIDTH  = 3'd4,
    CFG_GRID_HEIGHT = 3'd5,
    CFG_CLEARANCE   = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_OUTSIDE = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_RD1  = 2'd1,
    SEQ_RD2  = 2'd2,
    SEQ_RD3  = 2'd3
  } seq_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] origin_x;
    logic [DATA_W-1:0] origin_z;
    logic [INV_W-1:0]  inv_texel_x;
    logic [INV_W-1:0]  inv_texel_z;
    logic [DIM_W-1:0]  grid_width;
    logic [DIM_W-1:0]  grid_height;
    logic [DATA_W-1:0] clearance;
  } hbs_cfg_t;

  typedef struct packed {
    item_kind_e        kind;
    logic [ADDR_W-1:0] a00;
    logic [ADDR_W-1:0] a10;
    logic [ADDR_W-1:0] a01;
    logic [ADDR_W-1:0] a11;
    logic [FRAC_W-1:0] tx;
    logic [FRAC_W-1:0] tz;
    logic [DATA_W-1:0] cam;
    logic [DATA_W-1:0] wdata;
  } hbs_entry_t;

  // round to nearest, ties up, of a Q.24 product; low 32 bits of the result
  function automatic logic [DATA_W-1:0] rnd24(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] w;
    w = p + (PROD_W'(1) << (FRAC_W - 1));
    return w[FRAC_W +: DATA_W];
  endfunction

endpackage

@@ src/heightfield_bilinear_sampler_core.sv @@
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler_core
// Query: a query takes four reads of the single-port height memory, and the
//   next query's reads start once these are issued; a point outside the
//   grid skips them. Cell writes one per cycle, held by busy and query reads.
// busy rises when the 8-entry queue plus three front stages hold 8 items.
// Reset clears control, configuration and the loaded flag; the height memory
//   keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module heightfield_bilinear_sampler_core #(
  parameter int unsigned GRID_CELLS = hbs_pkg::GRID_CELLS_DEF,
  parameter int unsigned MAX_DIM    = hbs_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [hbs_pkg::IDX_W-1:0]     cell_index_i,
  input  logic [hbs_pkg::DATA_W-1:0]    cell_value_i,
  input  logic [hbs_pkg::DATA_W-1:0]    world_x_i,
  input  logic [hbs_pkg::DATA_W-1:0]    world_z_i,
  input  logic [hbs_pkg::DATA_W-1:0]    camera_y_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hbs_pkg::DATA_W-1:0]    cfg_data_i,
  output logic                          done_o,
  output logic [hbs_pkg::DATA_W-1:0]    ground_height_o,
  output logic                          outside_grid_o,
  output logic [hbs_pkg::DATA_W-1:0]    resolved_y_o,
  output logic                          collided_o
);
  import hbs_pkg::*;

  hbs_cfg_t         cfg_q, cfg_d;
  logic             push, pop, not_empty;
  hbs_entry_t       entry, head;
  logic [CNT_W-1:0] fifo_count;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ORIGIN_X:    cfg_d.origin_x    = cfg_data_i;
        CFG_ORIGIN_Z:    cfg_d.origin_z    = cfg_data_i;
        CFG_INV_TEXEL_X: cfg_d.inv_texel_x = cfg_data_i[INV_W-1:0];
        CFG_INV_TEXEL_Z: cfg_d.inv_texel_z = cfg_data_i[INV_W-1:0];
        CFG_GRID_WIDTH:  cfg_d.grid_width  = cfg_data_i[DIM_W-1:0];
        CFG_GRID_HEIGHT: cfg_d.grid_height = cfg_data_i[DIM_W-1:0];
        CFG_CLEARANCE:   cfg_d.clearance   = cfg_data_i;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= '0;
      cfg_q.origin_z    <= '0;
      cfg_q.inv_texel_x <= INV_RESET;
      cfg_q.inv_texel_z <= INV_RESET;
      cfg_q.grid_width  <= DIM_RESET;
      cfg_q.grid_height <= DIM_RESET;
      cfg_q.clearance   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hbs_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .op_i        (op_i),
    .cell_index_i(cell_index_i),
    .cell_value_i(cell_value_i),
    .world_x_i   (world_x_i),
    .world_z_i   (world_z_i),
    .camera_y_i  (camera_y_i),
    .cfg_i       (cfg_q),
    .fifo_count_i(fifo_count),
    .push_o      (push),
    .entry_o     (entry)
  );

  hbs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (entry),
    .pop_i      (pop),
    .head_o     (head),
    .not_empty_o(not_empty),
    .count_o    (fifo_count)
  );

  hbs_back #(
    .GRID_CELLS(GRID_CELLS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (not_empty),
    .pop_o          (pop),
    .clearance_i    (cfg_q.clearance),
    .done_o         (done_o),
    .ground_height_o(ground_height_o),
    .outside_grid_o (outside_grid_o),
    .resolved_y_o   (resolved_y_o),
    .collided_o     (collided_o)
  );

endmodule

@@ src/hbs_front.sv @@
// ----------------------------------------------------------------------------
// hbs_front
// Accepts items, maps query positions to grid cells and weights, classifies.
// ----------------------------------------------------------------------------
module hbs_front #(
  parameter int unsigned MAX_DIM = hbs_pkg::MAX_DIM_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         op_i,
  input  logic [hbs_pkg::IDX_W-1:0]    cell_index_i,
  input  logic [hbs_pkg::DATA_W-1:0]   cell_value_i,
  input  logic [hbs_pkg::DATA_W-1:0]   world_x_i,
  input  logic [hbs_pkg::DATA_W-1:0]   world_z_i,
  input  logic [hbs_pkg::DATA_W-1:0]   camera_y_i,
  input  hbs_pkg::hbs_cfg_t            cfg_i,
  input  logic [hbs_pkg::CNT_W-1:0]    fifo_count_i,
  output logic                         push_o,
  output hbs_pkg::hbs_entry_t          entry_o
);
  import hbs_pkg::*;

  typedef struct packed {
    logic              op;
    logic              loaded;
    logic [IDX_W-1:0]  cell_index;
    logic [DATA_W-1:0] cell_value;
    logic [DATA_W-1:0] cam;
    logic [DATA_W:0]   dx;
    logic [DATA_W:0]   dz;
  } s1_t;

  typedef struct packed {
    logic              op;
    logic              bad;
    logic [IDX_W-1:0]  cell_index;
    logic [DATA_W-1:0] cell_value;
    logic [DATA_W-1:0] cam;
    logic [UV_W-1:0]   u;
    logic [UV_W-1:0]   v;
  } s2_t;

  typedef struct packed {
    item_kind_e        kind;
    logic [IDX_W-1:0]  cell_index;
    logic [DATA_W-1:0] cell_value;
    logic [DATA_W-1:0] cam;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  x0;
    logic [DIM_W-1:0]  x1;
    logic [DIM_W-1:0]  z0;
    logic [DIM_W-1:0]  z1;
    logic [FRAC_W-1:0] tx;
    logic [FRAC_W-1:0] tz;
  } s3_t;

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (11'(d) > 11'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  logic              v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic              loaded_q, loaded_d;
  s1_t               s1_q, s1_d;
  s2_t               s2_q, s2_d;
  s3_t               s3_q, s3_d;
  logic              accept;
  logic [CNT_W:0]    total;
  logic [DIM_W-1:0]  w_c, h_c;
  logic              out_c;
  logic [DIM_W:0]    xn, zn;
  logic [ADDR_W-1:0] row0, row1;

  assign total  = (CNT_W+1)'(fifo_count_i) + (CNT_W+1)'(v1_q) + (CNT_W+1)'(v2_q)
                + (CNT_W+1)'(v3_q);
  assign busy_o = total >= (CNT_W+1)'(QDEPTH);
  assign accept = start_i && !busy_o;

  always_comb begin
    v1_d     = accept;
    v2_d     = v1_q;
    v3_d     = v2_q;
    loaded_d = loaded_q || (accept && (op_i == OP_WRITE));

    s1_d.op         = op_i;
    s1_d.loaded     = loaded_q;
    s1_d.cell_index = cell_index_i;
    s1_d.cell_value = cell_value_i;
    s1_d.cam        = camera_y_i;
    s1_d.dx         = {world_x_i[DATA_W-1], world_x_i}
                    - {cfg_i.origin_x[DATA_W-1], cfg_i.origin_x};
    s1_d.dz         = {world_z_i[DATA_W-1], world_z_i}
                    - {cfg_i.origin_z[DATA_W-1], cfg_i.origin_z};

    s2_d.op         = s1_q.op;
    s2_d.cell_index = s1_q.cell_index;
    s2_d.cell_value = s1_q.cell_value;
    s2_d.cam        = s1_q.cam;
    s2_d.bad        = !s1_q.loaded || (cfg_i.inv_texel_x == '0)
                   || (cfg_i.inv_texel_z == '0) || s1_q.dx[DATA_W] || s1_q.dz[DATA_W];
    s2_d.u          = UV_W'(s1_q.dx[DATA_W-1:0]) * UV_W'(cfg_i.inv_texel_x);
    s2_d.v          = UV_W'(s1_q.dz[DATA_W-1:0]) * UV_W'(cfg_i.inv_texel_z);

    w_c   = dim_clamp(cfg_i.grid_width);
    h_c   = dim_clamp(cfg_i.grid_height);
    out_c = s2_q.bad
         || (s2_q.u > UV_W'({w_c - DIM_W'(1), {FRAC_W{1'b0}}}))
         || (s2_q.v > UV_W'({h_c - DIM_W'(1), {FRAC_W{1'b0}}}));
    xn    = {1'b0, s2_q.u[FRAC_W +: DIM_W]} + (DIM_W+1)'(1);
    zn    = {1'b0, s2_q.v[FRAC_W +: DIM_W]} + (DIM_W+1)'(1);

    if (s2_q.op == OP_WRITE) begin
      s3_d.kind = KIND_WRITE;
    end else if (out_c) begin
      s3_d.kind = KIND_OUTSIDE;
    end else begin
      s3_d.kind = KIND_QUERY;
    end
    s3_d.cell_index = s2_q.cell_index;
    s3_d.cell_value = s2_q.cell_value;
    s3_d.cam        = s2_q.cam;
    s3_d.w          = w_c;
    s3_d.x0         = s2_q.u[FRAC_W +: DIM_W];
    s3_d.z0         = s2_q.v[FRAC_W +: DIM_W];
    s3_d.x1         = (xn < {1'b0, w_c}) ? xn[DIM_W-1:0] : w_c - DIM_W'(1);
    s3_d.z1         = (zn < {1'b0, h_c}) ? zn[DIM_W-1:0] : h_c - DIM_W'(1);
    s3_d.tx         = s2_q.u[FRAC_W-1:0];
    s3_d.tz         = s2_q.v[FRAC_W-1:0];
  end

  always_comb begin
    row0          = ADDR_W'(s3_q.z0) * ADDR_W'(s3_q.w);
    row1          = ADDR_W'(s3_q.z1) * ADDR_W'(s3_q.w);
    push_o        = v3_q;
    entry_o.kind  = s3_q.kind;
    entry_o.a00   = row0 + ADDR_W'(s3_q.x0);
    entry_o.a10   = row0 + ADDR_W'(s3_q.x1);
    entry_o.a01   = row1 + ADDR_W'(s3_q.x0);
    entry_o.a11   = row1 + ADDR_W'(s3_q.x1);
    entry_o.tx    = s3_q.tx;
    entry_o.tz    = s3_q.tz;
    entry_o.cam   = s3_q.cam;
    entry_o.wdata = s3_q.cell_value;
    if (s3_q.kind == KIND_WRITE) begin
      entry_o.a00 = ADDR_W'(s3_q.cell_index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      loaded_q <= 1'b0;
    end else begin
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      v3_q     <= v3_d;
      loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
  end

endmodule

@@ src/hbs_fifo.sv @@
// ----------------------------------------------------------------------------
// hbs_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module hbs_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  hbs_pkg::hbs_entry_t       entry_i,
  input  logic                      pop_i,
  output hbs_pkg::hbs_entry_t       head_o,
  output logic                      not_empty_o,
  output logic [hbs_pkg::CNT_W-1:0] count_o
);
  import hbs_pkg::*;

  hbs_entry_t       store_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_o      = store_q[rd_ptr_q];
  assign not_empty_o = count_q != '0;
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ src/hbs_back.sv @@
// ----------------------------------------------------------------------------
// hbs_back
// Height memory, four-read sequencer and bilinear / clamp pipeline.
// ----------------------------------------------------------------------------
module hbs_back #(
  parameter int unsigned GRID_CELLS = hbs_pkg::GRID_CELLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hbs_pkg::hbs_entry_t        head_i,
  input  logic                       head_valid_i,
  output logic                       pop_o,
  input  logic [hbs_pkg::DATA_W-1:0] clearance_i,
  output logic                       done_o,
  output logic [hbs_pkg::DATA_W-1:0] ground_height_o,
  output logic                       outside_grid_o,
  output logic [hbs_pkg::DATA_W-1:0] resolved_y_o,
  output logic                       collided_o
);
  import hbs_pkg::*;

  localparam int unsigned MEM_AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

  typedef struct packed {
    logic              outside;
    logic [PROD_W-1:0] p0;
    logic [PROD_W-1:0] p1;
    logic [DATA_W-1:0] h00;
    logic [DATA_W-1:0] h01;
    logic [FRAC_W-1:0] tz;
    logic [DATA_W-1:0] cam;
  } l1_t;

  typedef struct packed {
    logic              outside;
    logic [DATA_W-1:0] r0;
    logic [DATA_W-1:0] r1;
    logic [FRAC_W-1:0] tz;
    logic [DATA_W-1:0] cam;
  } l2_t;

  typedef struct packed {
    logic              outside;
    logic [PROD_W-1:0] p2;
    logic [DATA_W-1:0] r0;
    logic [DATA_W-1:0] cam;
  } l3_t;

  typedef struct packed {
    logic              outside;
    logic [DATA_W-1:0] ground;
    logic [DATA_W-1:0] cam;
  } l4_t;

  logic [DATA_W-1:0] mem_q [GRID_CELLS];
  seq_state_e        state_q, state_d, rstate_q, rstate_d;
  hbs_entry_t        cur_q, cur_d;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [MEM_AW-1:0] mem_idx;
  logic              mem_oob;
  logic [DATA_W-1:0] rdata_q;
  logic              rvalid_q, rvalid_d, roob_q, roob_d;
  logic [DATA_W-1:0] h00_q, h00_d, h10_q, h10_d, h01_q, h01_d;
  logic [DATA_W-1:0] rval;
  logic              last_rd, launch_out;
  logic              l1v_q, l1v_d, l2v_q, l2v_d, l3v_q, l3v_d, l4v_q, l4v_d;
  logic              done_q, done_d;
  l1_t               l1_q, l1_d;
  l2_t               l2_q, l2_d;
  l3_t               l3_q, l3_d;
  l4_t               l4_q, l4_d;
  logic signed [DATA_W:0]   d0, d1, d2;
  logic signed [PROD_W-1:0] m0, m1, m2;
  logic signed [DATA_W:0]   sum;
  logic [DATA_W-1:0] floor_y;
  logic              hit;
  logic [DATA_W-1:0] ground_q, ground_d, resolved_q, resolved_d;
  logic              outside_q, outside_d, collided_q, collided_d;

  assign mem_idx = MEM_AW'(mem_addr);
  assign mem_oob = 32'(mem_addr) >= 32'(GRID_CELLS);
  assign last_rd = rvalid_q && (rstate_q == SEQ_RD3);
  assign rval    = roob_q ? '0 : rdata_q;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = head_i.a00;
    rstate_d   = state_q;
    launch_out = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            KIND_WRITE: begin
              pop_o  = 1'b1;
              mem_we = !mem_oob;
            end
            KIND_QUERY: begin
              pop_o   = 1'b1;
              mem_re  = 1'b1;
              cur_d   = head_i;
              state_d = SEQ_RD1;
            end
            KIND_OUTSIDE: begin
              pop_o      = !last_rd;
              launch_out = !last_rd;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      SEQ_RD1: begin
        mem_re   = 1'b1;
        mem_addr = cur_q.a10;
        state_d  = SEQ_RD2;
      end
      SEQ_RD2: begin
        mem_re   = 1'b1;
        mem_addr = cur_q.a01;
        state_d  = SEQ_RD3;
      end
      SEQ_RD3: begin
        mem_re   = 1'b1;
        mem_addr = cur_q.a11;
        state_d  = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
    rvalid_d = mem_re;
    roob_d   = mem_oob;
  end

  always_comb begin
    h00_d = h00_q;
    h10_d = h10_q;
    h01_d = h01_q;
    if (rvalid_q) begin
      case (rstate_q)
        SEQ_IDLE: h00_d = rval;
        SEQ_RD1:  h10_d = rval;
        SEQ_RD2:  h01_d = rval;
        default:  ;
      endcase
    end

    d0 = $signed({h10_q[DATA_W-1], h10_q}) - $signed({h00_q[DATA_W-1], h00_q});
    d1 = $signed({rval[DATA_W-1], rval}) - $signed({h01_q[DATA_W-1], h01_q});
    m0 = PROD_W'(d0) * PROD_W'($signed({1'b0, cur_q.tx}));
    m1 = PROD_W'(d1) * PROD_W'($signed({1'b0, cur_q.tx}));

    l1v_d        = last_rd || launch_out;
    l1_d.outside = launch_out;
    l1_d.p0      = m0;
    l1_d.p1      = m1;
    l1_d.h00     = h00_q;
    l1_d.h01     = h01_q;
    l1_d.tz      = cur_q.tz;
    l1_d.cam     = launch_out ? head_i.cam : cur_q.cam;

    l2v_d        = l1v_q;
    l2_d.outside = l1_q.outside;
    l2_d.r0      = l1_q.h00 + rnd24(l1_q.p0);
    l2_d.r1      = l1_q.h01 + rnd24(l1_q.p1);
    l2_d.tz      = l1_q.tz;
    l2_d.cam     = l1_q.cam;

    d2           = $signed({l2_q.r1[DATA_W-1], l2_q.r1})
                 - $signed({l2_q.r0[DATA_W-1], l2_q.r0});
    m2           = PROD_W'(d2) * PROD_W'($signed({1'b0, l2_q.tz}));
    l3v_d        = l2v_q;
    l3_d.outside = l2_q.outside;
    l3_d.p2      = m2;
    l3_d.r0      = l2_q.r0;
    l3_d.cam     = l2_q.cam;

    l4v_d        = l3v_q;
    l4_d.outside = l3_q.outside;
    l4_d.ground  = l3_q.r0 + rnd24(l3_q.p2);
    l4_d.cam     = l3_q.cam;

    sum = $signed({l4_q.ground[DATA_W-1], l4_q.ground})
        + $signed({clearance_i[DATA_W-1], clearance_i});
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      floor_y = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      floor_y = sum[DATA_W-1:0];
    end
    hit = $signed(l4_q.cam) < $signed(floor_y);

    done_d = l4v_q;
    if (l4_q.outside) begin
      ground_d   = '0;
      outside_d  = 1'b1;
      resolved_d = l4_q.cam;
      collided_d = 1'b0;
    end else begin
      ground_d   = l4_q.ground;
      outside_d  = 1'b0;
      resolved_d = hit ? floor_y : l4_q.cam;
      collided_d = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      rvalid_q <= 1'b0;
      l1v_q    <= 1'b0;
      l2v_q    <= 1'b0;
      l3v_q    <= 1'b0;
      l4v_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      l1v_q    <= l1v_d;
      l2v_q    <= l2v_d;
      l3v_q    <= l3v_d;
      l4v_q    <= l4v_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    rstate_q   <= rstate_d;
    roob_q     <= roob_d;
    h00_q      <= h00_d;
    h10_q      <= h10_d;
    h01_q      <= h01_d;
    l1_q       <= l1_d;
    l2_q       <= l2_d;
    l3_q       <= l3_d;
    l4_q       <= l4_d;
    ground_q   <= ground_d;
    outside_q  <= outside_d;
    resolved_q <= resolved_d;
    collided_q <= collided_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_idx] <= head_i.wdata;
    end else if (mem_re) begin
      rdata_q <= mem_q[mem_idx];
    end
  end

  assign done_o          = done_q;
  assign ground_height_o = ground_q;
  assign outside_grid_o  = outside_q;
  assign resolved_y_o    = resolved_q;
  assign collided_o      = collided_q;

endmodule

@@ src/hbs_checker.sv @@
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the sampler core, bound to the top level.
// ----------------------------------------------------------------------------
module hbs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_i,
  input logic                          done_i,
  input logic [hbs_pkg::DATA_W-1:0]    ground_height_i,
  input logic                          outside_grid_i,
  input logic                          collided_i
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !busy_i && !done_i)
    else $error("busy or done high during reset");

  a_outside_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && outside_grid_i |-> (ground_height_i == '0) && !collided_i)
    else $error("outside result carries a height or a collision");

  a_busy_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_i) |-> $past(start_i && !busy_i))
    else $error("busy rose without an accepted transaction");

endmodule

bind heightfield_bilinear_sampler_core hbs_checker u_hbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .done_i         (done_o),
  .ground_height_i(ground_height_o),
  .outside_grid_i (outside_grid_o),
  .collided_i     (collided_o)
);
